// File: hdl/ghi_pkg.sv
// Shared types, widths and codes for the gyro heading integrator.
`default_nettype none
package ghi_pkg;

	// Transaction payloads
	typedef struct packed {
		logic [1:0]         func;
		logic signed [15:0] rate_sample;
		logic [31:0]        tick_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] angle_millideg;
		logic signed [15:0] last_rate;
		logic signed [15:0] bias_value;
		logic               calibration_done;
	} out_item_t;

	// Item function codes
	localparam logic [1:0] FUNC_CALIB  = 2'd0;
	localparam logic [1:0] FUNC_UPDATE = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	// Field and state widths
	localparam int SAMPLE_W = 16;
	localparam int TICK_W   = 32;
	localparam int ACC_W    = 64;
	localparam int BSUM_W   = 27;
	localparam int CCNT_W   = 10;
	localparam int SCALE_W  = 11;
	localparam int SUM_W    = 19;             // sample + two history - 3*bias
	localparam int PROD_W   = TICK_W + 1 + SUM_W;

	// Shared divider: dividend wide enough for accumulator * 10
	localparam int DIV_W   = ACC_W + 4;
	localparam int DVSR_W  = SCALE_W;
	localparam int DCNT_W  = $clog2(DIV_W + 1);
	localparam logic [DVSR_W-1:0] TERM_DIVISOR = DVSR_W'(3);

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REGIDX_W = PADDR_W - 2;
	localparam logic [REGIDX_W-1:0] REG_SCALE = REGIDX_W'(0);
	localparam logic [SCALE_W-1:0]  SCALE_RESET = SCALE_W'(164);

	typedef struct packed {
		logic                    start;
		logic signed [DIV_W-1:0] dividend;
		logic [DVSR_W-1:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic                    busy;
		logic                    done;
		logic signed [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

// File: hdl/ghi_apb_regs.sv
// Configuration register file behind an APB-style port.
`default_nettype none
module ghi_apb_regs import ghi_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready,
	output logic [SCALE_W-1:0]      scale
);

	logic [SCALE_W-1:0]  scale_q;
	logic [REGIDX_W-1:0] reg_idx;
	logic                wr_en;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && (reg_idx == REG_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (wr_en) begin
			scale_q <= pwdata[SCALE_W-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SCALE: prdata = PDATA_W'(scale_q);
			default:   prdata = '0;
		endcase
	end

	assign scale = scale_q;

endmodule
`default_nettype wire

// File: hdl/ghi_divider.sv
// Shared restoring divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module ghi_divider import ghi_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                    run_q;
	logic                    fin_q;
	logic                    done_q;
	logic [DCNT_W-1:0]       cnt_q;
	logic                    neg_q;
	logic [DIV_W-1:0]        quo_q;
	logic [DVSR_W-1:0]       rem_q;
	logic [DVSR_W-1:0]       dvsr_q;
	logic signed [DIV_W-1:0] res_q;

	logic [DVSR_W:0] trial;
	logic [DVSR_W:0] diff;
	logic            ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvsr_q};
	assign ge    = trial >= {1'b0, dvsr_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= run_q && (cnt_q == DCNT_W'(1));
			if (req.start && !run_q && !fin_q) begin
				run_q <= 1'b1;
				cnt_q <= DCNT_W'(DIV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == DCNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: load magnitude, shift/subtract, restore sign at the end
	always_ff @(posedge clk) begin
		if (req.start && !run_q && !fin_q) begin
			neg_q  <= req.dividend[DIV_W-1];
			quo_q  <= req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : DIV_W'(req.dividend);
			rem_q  <= '0;
			dvsr_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
		if (fin_q) begin
			res_q <= neg_q ? -$signed(quo_q) : $signed(quo_q);
		end
	end

	assign rsp.busy     = run_q || fin_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = res_q;

endmodule
`default_nettype wire

// File: hdl/gyro_heading_integrator_top.sv
// Top level of the gyro heading integrator: sequencer, state and result register.
//
// Usage: items enter on in_valid/in_stall/in_data; one transaction is taken at a
// rising edge with in_valid high and in_stall low. func selects a calibration
// sample, an angle update sample, a clear of the angle, or (code 3) a plain
// status read. Every item yields exactly one result transaction on
// out_valid/out_stall/out_data carrying the heading in millidegrees, the newest
// history sample, the bias and a flag marking the end of a calibration run.
// Flow: one item at a time; in_stall stays high from accept until the result
// is loaded. Every item passes through the single 68-step divider to form the
// heading (accumulator*10/scale); an update or a final calibration item runs it
// once before that as well, for the term/3 or the bias average.
// The APB-style port holds rate_lsb_per_dps_x10 at byte address 0; write it
// only while the block is idle. A value of zero acts as one.
// Reset clears the sequencer, calibration and heading state to zero and the scale
// register to 164; no clearing pass is needed. When the receiver stalls, the
// result register holds its transaction; the next item is accepted meanwhile
// and its result waits in the sequencer until the register frees.
`default_nettype none
module gyro_heading_integrator_top import ghi_pkg::*; #(
	parameter int CALIB_SAMPLES = 75
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire in_item_t           in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output out_item_t               out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	localparam logic [CCNT_W-1:0] CALIB_N = CCNT_W'(CALIB_SAMPLES);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_CAL        = 4'd1;
	localparam logic [3:0] S_BIAS_GO    = 4'd2;
	localparam logic [3:0] S_BIAS_WAIT  = 4'd3;
	localparam logic [3:0] S_MUL        = 4'd4;
	localparam logic [3:0] S_TERM_GO    = 4'd5;
	localparam logic [3:0] S_TERM_WAIT  = 4'd6;
	localparam logic [3:0] S_ANGLE_X10  = 4'd7;
	localparam logic [3:0] S_ANGLE_GO   = 4'd8;
	localparam logic [3:0] S_ANGLE_WAIT = 4'd9;
	localparam logic [3:0] S_OUT        = 4'd10;

	logic [3:0]               state_q;
	in_item_t                 item_q;
	logic signed [BSUM_W-1:0] bias_sum_q;
	logic [CCNT_W-1:0]        calib_count_q;
	logic signed [SAMPLE_W-1:0] bias_q;
	logic signed [SAMPLE_W-1:0] hist_new_q;
	logic signed [SAMPLE_W-1:0] hist_old_q;
	logic [TICK_W-1:0]        prev_tick_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DIV_W-1:0]  wide_q;
	logic signed [ACC_W-1:0]  angle_q;
	logic                     done_flag_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic [SCALE_W-1:0]  scale;
	logic [SCALE_W-1:0]  scale_eff;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	logic                     in_take;
	logic                     out_free;
	logic signed [BSUM_W-1:0] sum_next;
	logic [CCNT_W-1:0]        cnt_next;
	logic [TICK_W-1:0]        dt;
	logic signed [SUM_W-1:0]  rate_sum;
	logic signed [PROD_W-1:0] prod;
	logic signed [DIV_W-1:0]  acc_ext;

	ghi_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.scale   (scale)
	);

	ghi_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_take   = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign scale_eff = (scale == '0) ? SCALE_W'(1) : scale;

	// Calibration bookkeeping
	assign sum_next = bias_sum_q + BSUM_W'(item_q.rate_sample);
	assign cnt_next = calib_count_q + CCNT_W'(1);

	// Update term numerator: dt * (sample + newest + older - 3*bias)
	assign dt       = item_q.tick_ms - prev_tick_q;
	assign rate_sum = SUM_W'(item_q.rate_sample) + SUM_W'(hist_new_q) + SUM_W'(hist_old_q)
		- ((SUM_W'(bias_q) <<< 1) + SUM_W'(bias_q));
	assign prod     = $signed({1'b0, dt}) * rate_sum;
	assign acc_ext  = DIV_W'(acc_q);

	// Divider requests: one per GO state
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = wide_q;
		div_req.divisor  = scale_eff;
		case (state_q)
			S_BIAS_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(bias_sum_q);
				div_req.divisor  = DVSR_W'(CALIB_N);
			end
			S_TERM_GO: begin
				div_req.start   = 1'b1;
				div_req.divisor = TERM_DIVISOR;
			end
			S_ANGLE_GO: begin
				div_req.start = 1'b1;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			bias_sum_q    <= '0;
			calib_count_q <= '0;
			bias_q        <= '0;
			hist_new_q    <= '0;
			hist_old_q    <= '0;
			prev_tick_q   <= '0;
			acc_q         <= '0;
			done_flag_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						done_flag_q <= 1'b0;
						case (in_data.func)
							FUNC_CALIB:  state_q <= S_CAL;
							FUNC_UPDATE: state_q <= S_MUL;
							FUNC_CLEAR: begin
								acc_q   <= '0;
								state_q <= S_ANGLE_X10;
							end
							default:     state_q <= S_ANGLE_X10;
						endcase
					end
				end
				S_CAL: begin
					bias_sum_q <= sum_next;
					if (cnt_next >= CALIB_N) begin
						calib_count_q <= '0;
						state_q       <= S_BIAS_GO;
					end else begin
						calib_count_q <= cnt_next;
						state_q       <= S_ANGLE_X10;
					end
				end
				S_BIAS_GO: state_q <= S_BIAS_WAIT;
				S_BIAS_WAIT: begin
					if (div_rsp.done) begin
						bias_q      <= div_rsp.quotient[SAMPLE_W-1:0];
						hist_new_q  <= div_rsp.quotient[SAMPLE_W-1:0];
						hist_old_q  <= div_rsp.quotient[SAMPLE_W-1:0];
						bias_sum_q  <= '0;
						done_flag_q <= 1'b1;
						state_q     <= S_ANGLE_X10;
					end
				end
				S_MUL:     state_q <= S_TERM_GO;
				S_TERM_GO: state_q <= S_TERM_WAIT;
				S_TERM_WAIT: begin
					if (div_rsp.done) begin
						acc_q       <= acc_q + div_rsp.quotient[ACC_W-1:0];
						hist_old_q  <= hist_new_q;
						hist_new_q  <= item_q.rate_sample;
						prev_tick_q <= item_q.tick_ms;
						state_q     <= S_ANGLE_X10;
					end
				end
				S_ANGLE_X10: state_q <= S_ANGLE_GO;
				S_ANGLE_GO:  state_q <= S_ANGLE_WAIT;
				S_ANGLE_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// Hold the result until the output register frees
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result valid: set on load, drop once the receiver takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_q <= in_data;
		end
		case (state_q)
			S_MUL:        wide_q <= DIV_W'(prod);
			S_ANGLE_X10:  wide_q <= (acc_ext <<< 3) + (acc_ext <<< 1);
			default:      wide_q <= wide_q;
		endcase
		if (state_q == S_ANGLE_WAIT && div_rsp.done) begin
			angle_q <= div_rsp.quotient[ACC_W-1:0];
		end
		if (state_q == S_OUT && out_free) begin
			out_q.angle_millideg   <= angle_q;
			out_q.last_rate        <= hist_new_q;
			out_q.bias_value       <= bias_q;
			out_q.calibration_done <= done_flag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_BIAS_WAIT || state_q == S_TERM_WAIT ||
			state_q == S_ANGLE_WAIT))
		else $error("divider result with no waiting step");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		calib_count_q < CALIB_N)
		else $error("calibration count ran past the run length");

	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result loaded outside the output step");

	a_take_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("sequencer did not leave idle after a transaction");

endmodule
`default_nettype wire

// File: bench/ghi_heading_checker.sv
// Checker for the gyro heading integrator: watches both channels, predicts and compares.
module ghi_heading_checker import ghi_pkg::*; #(
	parameter int CALIB_N = 75
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire in_item_t           in_data,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire out_item_t          out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic               pready,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output int                      mismatches,
	output int                      outstanding,
	output int                      results_seen,
	output int                      calib_completions
);

	logic [SCALE_W-1:0]         scale;
	logic signed [BSUM_W-1:0]   bias_sum;
	logic [CCNT_W-1:0]          calib_cnt;
	logic signed [SAMPLE_W-1:0] bias;
	logic signed [SAMPLE_W-1:0] hist_new;
	logic signed [SAMPLE_W-1:0] hist_old;
	logic [TICK_W-1:0]          prev_tick;
	logic [ACC_W-1:0]           heading_acc;
	out_item_t                  pending_results[$];
	out_item_t                  want;

	// Advance the heading state by one item and return the result it must produce.
	function automatic out_item_t integrate_item(in_item_t it);
		out_item_t          r;
		logic               done;
		logic [TICK_W-1:0]  dt;
		longint             rate_sum;
		longint             term;
		logic [SCALE_W-1:0] divisor;
		logic signed [67:0] scaled;
		r = '0;
		done = 1'b0;
		case (it.func)
			FUNC_CALIB: begin
				bias_sum = bias_sum + it.rate_sample;
				calib_cnt = calib_cnt + 1'b1;
				if (calib_cnt >= CALIB_N) begin
					bias = 16'(bias_sum / CALIB_N);
					hist_new = bias;
					hist_old = bias;
					bias_sum = '0;
					calib_cnt = '0;
					done = 1'b1;
				end
			end
			FUNC_UPDATE: begin
				dt = it.tick_ms - prev_tick;
				rate_sum = longint'(it.rate_sample) + longint'(hist_new) + longint'(hist_old)
					- 3 * longint'(bias);
				term = $signed({32'd0, dt}) * rate_sum / 3;
				heading_acc = heading_acc + term;
				hist_old = hist_new;
				hist_new = it.rate_sample;
				prev_tick = it.tick_ms;
			end
			FUNC_CLEAR: heading_acc = '0;
			default: ;
		endcase
		divisor = (scale == '0) ? SCALE_W'(1) : scale;
		scaled = $signed(heading_acc) * 68'sd10;
		scaled = scaled / $signed({57'd0, divisor});
		r.angle_millideg = scaled[63:0];
		r.last_rate = hist_new;
		r.bias_value = bias;
		r.calibration_done = done;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale = SCALE_RESET;
			bias_sum = '0;
			calib_cnt = '0;
			bias = '0;
			hist_new = '0;
			hist_old = '0;
			prev_tick = '0;
			heading_acc = '0;
			pending_results.delete();
			mismatches = 0;
			outstanding = 0;
			results_seen = 0;
			calib_completions = 0;
		end else begin
			// Results first: one accepted at this edge cannot come from an item taken at it.
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("unexpected result: angle_millideg %0d, nothing expected",
						out_data.angle_millideg);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (out_data.angle_millideg !== want.angle_millideg) begin
						$error("angle_millideg: expected %0d, got %0d",
							want.angle_millideg, out_data.angle_millideg);
						mismatches++;
					end
					if (out_data.last_rate !== want.last_rate) begin
						$error("last_rate: expected %0d, got %0d",
							want.last_rate, out_data.last_rate);
						mismatches++;
					end
					if (out_data.bias_value !== want.bias_value) begin
						$error("bias_value: expected %0d, got %0d",
							want.bias_value, out_data.bias_value);
						mismatches++;
					end
					if (out_data.calibration_done !== want.calibration_done) begin
						$error("calibration_done: expected %0d, got %0d",
							want.calibration_done, out_data.calibration_done);
						mismatches++;
					end
					if (want.calibration_done)
						calib_completions++;
				end
			end
			if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_SCALE)
				scale = pwdata[SCALE_W-1:0];
			if (in_valid && !in_stall)
				pending_results.push_back(integrate_item(in_data));
			outstanding = pending_results.size();
		end
	end

endmodule

// File: bench/gyro_heading_integrator_top_tb.sv
// Testbench top for the gyro heading integrator: stimulus, pacing and verdict.
module gyro_heading_integrator_top_tb;
	import ghi_pkg::*;

	localparam int CALIB_N      = 75;
	localparam int PHASE_ITEMS  = 80;    // random transactions per pacing phase
	localparam int SINK_HOLD    = 1500;  // long sink hold
	localparam int WRAP_RUN     = 20;    // largest-term updates at the zero scale
	localparam int DRAIN_CYCLES = 200;   // beyond the slowest item latency

	localparam logic [1:0]         FUNC_STATUS = 2'd3;  // unused code, reports state only
	localparam logic [SCALE_W-1:0] SCALE_ZERO  = SCALE_W'(0);
	localparam logic [SCALE_W-1:0] SCALE_ONE   = SCALE_W'(1);
	localparam logic [SCALE_W-1:0] SCALE_TOP   = SCALE_W'(1310);
	localparam logic [SCALE_W-1:0] SCALE_FULL  = '1;

	typedef enum logic [1:0] {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_item_t          out_data;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	pace_t              pace;
	logic               hold_sink;
	int                 items_sent;
	int                 calib_in_run;   // calibration transactions since the last completed run
	logic [TICK_W-1:0]  last_tick;      // time stamp of the last update transaction sent
	int                 mismatches;
	int                 outstanding;
	int                 results_seen;
	int                 calib_completions;

	gyro_heading_integrator_top #(
		.CALIB_SAMPLES(CALIB_N)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	ghi_heading_checker #(
		.CALIB_N(CALIB_N)
	) checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_data          (in_data),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_data         (out_data),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.pready           (pready),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.mismatches       (mismatches),
		.outstanding      (outstanding),
		.results_seen     (results_seen),
		.calib_completions(calib_completions)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs; the slowest correct run needs well under a third.
	initial begin
		#30_000_000;
		$display("Timeout: %0d transactions sent, %0d results still awaited",
			items_sent, outstanding);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int clamp16(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int any_rate();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic in_item_t make_item(logic [1:0] f, int rate, logic [TICK_W-1:0] t);
		in_item_t it;
		it.func = f;
		it.rate_sample = SAMPLE_W'(rate);
		it.tick_ms = t;
		return it;
	endfunction

	// Source idling per cycle, set by the current pacing phase.
	function automatic logic source_gap();
		case (pace)
			PACE_SLOW_SINK:   return $urandom_range(0, 99) < 7;
			PACE_SLOW_SOURCE: return $urandom_range(0, 99) < 88;
			default:          return 1'b0;
		endcase
	endfunction

	function automatic logic sink_stall();
		case (pace)
			PACE_SLOW_SINK:   return $urandom_range(0, 99) < 88;
			PACE_SLOW_SOURCE: return $urandom_range(0, 99) < 7;
			default:          return 1'b0;
		endcase
	endfunction

	// Offer one transaction and hold it until the block takes it. Returns at the accept edge
	// with valid still high, so back-to-back transactions need no extra assignment.
	task automatic send_item(in_item_t it);
		while (source_gap()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		if (it.func == FUNC_CALIB)
			calib_in_run = (calib_in_run + 1) % CALIB_N;
		if (it.func == FUNC_UPDATE)
			last_tick = it.tick_ms;
	endtask

	// Drop valid and wait until every result has come back; end on a rising edge.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Setup then access phase; pready is sampled for form's sake.
	task automatic write_scale(logic [SCALE_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_SCALE, 2'b00};
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Calibration samples scattered around one offset, now and then a wild reading.
	task automatic calib_run(int len);
		int center;
		int rate;
		case ($urandom_range(0, 7))
			0:       center = -32768;
			1:       center = 32767;
			default: center = int'($urandom_range(0, 4000)) - 2000;
		endcase
		repeat (len) begin
			if ($urandom_range(0, 9) == 0)
				rate = any_rate();
			else
				rate = clamp16(center + int'($urandom_range(0, 200)) - 100);
			send_item(make_item(FUNC_CALIB, rate, $urandom()));
		end
	endtask

	// Updates with time stamps that mostly advance a few ms; some stand still or jump anywhere.
	task automatic update_burst(int len);
		logic [TICK_W-1:0] dt;
		int                rate;
		repeat (len) begin
			case ($urandom_range(0, 9))
				0:       dt = '0;
				1:       dt = $urandom();
				default: dt = $urandom_range(1, 20);
			endcase
			if ($urandom_range(0, 7) == 0)
				rate = any_rate();
			else
				rate = int'($urandom_range(0, 6000)) - 3000;
			send_item(make_item(FUNC_UPDATE, rate, last_tick + dt));
		end
	endtask

	// Mostly whole calibration runs and update bursts; partial runs, clears,
	// status reads and random transactions mixed in.
	task automatic run_phase(int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1:
					calib_run(($urandom_range(0, 3) == 0) ? $urandom_range(1, CALIB_N - 1)
						: CALIB_N);
				2, 3, 4, 5, 6:
					update_burst($urandom_range(5, 30));
				7:
					send_item(make_item(FUNC_CLEAR, any_rate(), $urandom()));
				8:
					send_item(make_item(FUNC_STATUS, any_rate(), $urandom()));
				default:
					send_item(make_item(2'($urandom_range(0, 3)), any_rate(), $urandom()));
			endcase
		end
	endtask

	// Sink side: random stalls by phase, plus one long hold counted here while the
	// source keeps offering, so the block fills and stalls its input.
	initial begin
		logic held;
		held = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_sink && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (SINK_HOLD)
					@(posedge clk);
			end
			out_stall <= sink_stall();
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pace <= PACE_SLOW_SINK;
		hold_sink <= 1'b0;
		items_sent = 0;
		calib_in_run = 0;
		last_tick = '0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset scale: status read on fresh state, zero elapsed time,
		// rate extremes, a huge elapsed time and a wrapping time stamp, ignored fields on
		// status and clear, alternating bit patterns, and a few calibration extremes.
		send_item(make_item(FUNC_STATUS, 0, 32'h0000_0000));
		send_item(make_item(FUNC_UPDATE, 0, 32'h0000_0000));
		send_item(make_item(FUNC_UPDATE, 32767, 32'h0000_0001));
		send_item(make_item(FUNC_UPDATE, -32768, 32'h0000_03E9));
		send_item(make_item(FUNC_UPDATE, -1, 32'hFFFF_FFFF));
		send_item(make_item(FUNC_UPDATE, 1, 32'h0000_0005));
		send_item(make_item(FUNC_STATUS, -32768, 32'hFFFF_FFFF));
		send_item(make_item(FUNC_CLEAR, 32767, 32'hFFFF_FFFF));
		send_item(make_item(FUNC_UPDATE, 16'sh5555, 32'hAAAA_AAAA));
		send_item(make_item(FUNC_UPDATE, -21846, 32'h5555_5555));
		send_item(make_item(FUNC_CALIB, 32767, 32'h0000_0000));
		send_item(make_item(FUNC_CALIB, -32768, 32'hFFFF_FFFF));
		send_item(make_item(FUNC_CALIB, -1, 32'h1234_5678));
		send_item(make_item(FUNC_UPDATE, 100, last_tick + 32'd7));
		send_item(make_item(FUNC_CLEAR, 0, 32'h0000_0000));

		// Phase one: slow sink, top of the usual scale range.
		wait_idle();
		write_scale(SCALE_TOP);
		run_phase(PHASE_ITEMS);

		// Phase two: slow source, smallest scale.
		wait_idle();
		pace <= PACE_SLOW_SOURCE;
		write_scale(SCALE_ONE);
		run_phase(PHASE_ITEMS);

		// Phase three: full rate with the long sink hold, all-ones scale.
		wait_idle();
		pace <= PACE_FULL;
		write_scale(SCALE_FULL);
		hold_sink <= 1'b1;
		run_phase(PHASE_ITEMS);

		// Largest terms: finish any open calibration run, then calibrate to the most
		// negative bias so every update adds the largest term over the longest elapsed
		// time, with a zero scale acting as one.
		repeat ((CALIB_N - calib_in_run) % CALIB_N)
			send_item(make_item(FUNC_CALIB, -32768, $urandom()));
		repeat (CALIB_N)
			send_item(make_item(FUNC_CALIB, -32768, $urandom()));
		send_item(make_item(FUNC_CLEAR, 0, $urandom()));
		wait_idle();
		write_scale(SCALE_ZERO);
		repeat (WRAP_RUN)
			send_item(make_item(FUNC_UPDATE, 32767, last_tick - 32'd1));

		wait_idle();
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Summary: %0d transactions sent, %0d results checked, %0d calibration runs",
			items_sent, results_seen, calib_completions);
		$display("%0d mismatches; scales 164/1310/1/2047/0, both idling mixes, long sink hold",
			mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
